// ===== rtl/core/cda_pkg.sv =====
// Shared types, codes and helpers for the contiguous descriptor allocator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package cda_pkg;

  localparam int POOL_ENTRIES_DEF = 32;
  localparam int MAX_RECORDS_DEF  = 16;
  localparam int MAP_W            = 32;

  localparam logic [1:0] OP_ALLOC    = 2'd0;
  localparam logic [1:0] OP_ACTIVATE = 2'd1;
  localparam logic [1:0] OP_COMPLETE = 2'd2;
  localparam logic [1:0] OP_FREE     = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_BAD_RANGE = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_HW_FAIL   = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] run_length;
    logic [4:0] first_index;
    logic       outcome;
  } req_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  run_start;
    logic [5:0]  run_freed;
    logic [4:0]  records_held;
    logic [31:0] busy_map;
  } rsp_word_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SEARCH,
    CS_COMMIT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic search;
    logic commit;
  } cda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } cda_sts_t;

  // Mask of len entries starting at start, clipped to the map width.
  function automatic logic [MAP_W-1:0] run_mask(input logic [4:0] start,
                                                input logic [5:0] len);
    logic [63:0] m;
    m = ((64'd1 << len) - 64'd1) << start;
    return m[MAP_W-1:0];
  endfunction

endpackage

// ===== rtl/core/cda_ctrl.sv =====
// Sequencer for the allocator: load, search, commit.
// Depends on cda_pkg; drives the command struct of cda_dpath.
`timescale 1ns / 1ps

module cda_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output cda_pkg::cda_cmd_t cmd,
  input  cda_pkg::cda_sts_t sts
);
  import cda_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (req_valid) state_next = CS_SEARCH;
      end
      CS_SEARCH: state_next = CS_COMMIT;
      CS_COMMIT: begin
        // hold until the result register can take the word
        if (sts.out_free) state_next = CS_IDLE;
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = 1'b1;
    cmd.load   = 1'b0;
    cmd.search = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      CS_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      CS_SEARCH: cmd.search = 1'b1;
      CS_COMMIT: cmd.commit = sts.out_free;
      default: req_stall = 1'b1;
    endcase
  end

endmodule

// ===== rtl/core/cda_dpath.sv =====
// Datapath: used-bit map, tracking records, run search and result register.
// Depends on cda_pkg; steered by cda_ctrl through cda_cmd_t.
`timescale 1ns / 1ps

module cda_dpath #(
  parameter int POOL_ENTRIES = cda_pkg::POOL_ENTRIES_DEF,
  parameter int MAX_RECORDS  = cda_pkg::MAX_RECORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cda_pkg::req_word_t req,
  input  cda_pkg::cda_cmd_t  cmd,
  output cda_pkg::cda_sts_t  sts,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output cda_pkg::rsp_word_t rsp
);
  import cda_pkg::*;

  localparam int FILL_W = $clog2(MAX_RECORDS + 1);
  localparam int IDX_W  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

  req_word_t        item;
  logic [MAP_W-1:0] used;
  logic [4:0]       rec_start [MAX_RECORDS];
  logic [5:0]       rec_len   [MAX_RECORDS];
  logic             rec_act   [MAX_RECORDS];
  logic [FILL_W-1:0] fill;

  // search results, registered for the commit cycle
  logic             alloc_found;
  logic [4:0]       alloc_idx;
  logic             act_found;
  logic [IDX_W-1:0] act_idx;
  logic             cpl_found;
  logic [IDX_W-1:0] cpl_idx;
  logic [4:0]       cpl_start;
  logic [5:0]       cpl_len;

  logic             alloc_found_next;
  logic [4:0]       alloc_idx_next;
  logic             act_found_next;
  logic [IDX_W-1:0] act_idx_next;
  logic             cpl_found_next;
  logic [IDX_W-1:0] cpl_idx_next;

  logic [MAP_W-1:0] base;
  logic [MAP_W-1:0] fit;
  logic [MAX_RECORDS-1:0] act_hit;
  logic [MAX_RECORDS-1:0] cpl_hit;
  logic             len_ok;

  assign sts.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) item <= req;
  end

  // Search: candidate starts and record matches in parallel, lowest wins.
  always_comb begin
    len_ok = (item.run_length != 6'd0) && (7'(item.run_length) <= 7'(POOL_ENTRIES));
    base   = run_mask(5'd0, item.run_length);
    for (int i = 0; i < MAP_W; i++) begin
      fit[i] = ((7'(item.run_length) + 7'(i)) <= 7'(POOL_ENTRIES)) &&
               (((used >> i) & base) == '0);
    end
    for (int k = 0; k < MAX_RECORDS; k++) begin
      act_hit[k] = (FILL_W'(k) < fill) && !rec_act[k] &&
                   (rec_start[k] == item.first_index) &&
                   (rec_len[k] == item.run_length);
      cpl_hit[k] = (FILL_W'(k) < fill) && rec_act[k];
    end
    alloc_found_next = 1'b0;
    alloc_idx_next   = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (fit[i]) begin
        alloc_found_next = 1'b1;
        alloc_idx_next   = 5'(i);
      end
    end
    act_found_next = 1'b0;
    act_idx_next   = '0;
    cpl_found_next = 1'b0;
    cpl_idx_next   = '0;
    for (int k = MAX_RECORDS - 1; k >= 0; k--) begin
      if (act_hit[k]) begin
        act_found_next = 1'b1;
        act_idx_next   = IDX_W'(k);
      end
      if (cpl_hit[k]) begin
        cpl_found_next = 1'b1;
        cpl_idx_next   = IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      alloc_found <= alloc_found_next && len_ok;
      alloc_idx   <= alloc_idx_next;
      act_found   <= act_found_next;
      act_idx     <= act_idx_next;
      cpl_found   <= cpl_found_next;
      cpl_idx     <= cpl_idx_next;
      cpl_start   <= rec_start[cpl_idx_next];
      cpl_len     <= rec_len[cpl_idx_next];
    end
  end

  // Commit: next map, record edits and result word.
  logic [MAP_W-1:0]  used_next;
  logic [FILL_W-1:0] fill_next;
  logic              do_append;
  logic              do_activate;
  logic              do_remove;
  logic              cpl_fits;
  logic              free_fits;
  logic [6:0]        fill_ext;
  rsp_word_t         result;

  always_comb begin
    cpl_fits  = (7'(cpl_start) < 7'(POOL_ENTRIES)) && (cpl_len != 6'd0) &&
                ((7'(cpl_start) + 7'(cpl_len)) <= 7'(POOL_ENTRIES));
    free_fits = (7'(item.first_index) < 7'(POOL_ENTRIES)) &&
                (item.run_length != 6'd0) &&
                ((7'(item.first_index) + 7'(item.run_length)) <= 7'(POOL_ENTRIES));
    used_next   = used;
    fill_next   = fill;
    do_append   = 1'b0;
    do_activate = 1'b0;
    do_remove   = 1'b0;
    result      = '0;
    case (item.opcode)
      OP_ALLOC: begin
        result.status = ST_NO_SPACE;
        if (alloc_found) begin
          used_next        = used | run_mask(alloc_idx, item.run_length);
          result.status    = ST_OK;
          result.run_start = alloc_idx;
          if (fill < FILL_W'(MAX_RECORDS)) begin
            do_append = 1'b1;
            fill_next = fill + FILL_W'(1);
          end
        end
      end
      OP_ACTIVATE: begin
        if (item.run_length == 6'd0) begin
          result.status = ST_BAD_RANGE;
        end else if (act_found) begin
          do_activate   = 1'b1;
          result.status = ST_OK;
        end else begin
          result.status = ST_NOT_FOUND;
        end
      end
      OP_COMPLETE: begin
        if (cpl_found) begin
          do_remove = 1'b1;
          fill_next = fill - FILL_W'(1);
          if (cpl_fits) begin
            used_next        = used & ~run_mask(cpl_start, cpl_len);
            result.run_start = cpl_start;
            result.run_freed = cpl_len;
          end
        end
        result.status = item.outcome ? ST_HW_FAIL : ST_OK;
      end
      OP_FREE: begin
        if (free_fits) begin
          used_next        = used & ~run_mask(item.first_index, item.run_length);
          result.status    = ST_OK;
          result.run_start = item.first_index;
          result.run_freed = item.run_length;
        end else begin
          result.status = ST_BAD_RANGE;
        end
      end
      default: result.status = ST_OK;
    endcase
    fill_ext            = 7'(fill_next);
    result.records_held = fill_ext[4:0];
    result.busy_map     = used_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      fill <= '0;
    end else if (cmd.commit) begin
      used <= used_next;
      fill <= fill_next;
    end
  end

  // Record list: append at the fill point, close the gap on removal.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int k = 0; k < MAX_RECORDS; k++) begin
        if (do_append && fill[IDX_W-1:0] == IDX_W'(k)) begin
          rec_start[k] <= alloc_idx;
          rec_len[k]   <= item.run_length;
          rec_act[k]   <= 1'b0;
        end
        if (do_activate && act_idx == IDX_W'(k)) begin
          rec_act[k] <= 1'b1;
        end
        if (do_remove && IDX_W'(k) >= cpl_idx && k + 1 < MAX_RECORDS) begin
          rec_start[k] <= rec_start[(k + 1) % MAX_RECORDS];
          rec_len[k]   <= rec_len[(k + 1) % MAX_RECORDS];
          rec_act[k]   <= rec_act[(k + 1) % MAX_RECORDS];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) rsp <= result;
  end

endmodule

// ===== rtl/core/contiguous_descriptor_allocator.sv =====
// Top level of the contiguous descriptor allocator.
// Depends on cda_pkg, cda_ctrl and cda_dpath.
//
// Usage:
//   Request channel (req_valid, req_stall, req): one word per operation,
//   opcode allocate, activate record, complete transfer or free range.
//   Response channel (rsp_valid, rsp_stall, rsp): exactly one word per
//   request with status, run start, entries freed, record count and the
//   used-bit map after the operation.
//   A request is taken when valid is high and stall is low.
// Sequence:
//   A request is loaded at its accepting edge, searched in the SEARCH
//   state (all candidate starts and all records compared at once, results
//   registered) and committed in the COMMIT state once the response
//   register is free, which registers the response word. A new request is
//   taken only once the last one has committed, so requests do not overlap.
// Reset:
//   rst (synchronous) clears the used-bit map, the record count, the
//   sequencer state and the response valid flag; record contents are left.
// Back pressure:
//   While rsp_stall is high the response word holds. The next request is
//   still accepted and searched, then waits in commit until the response
//   register is free.
`timescale 1ns / 1ps

module contiguous_descriptor_allocator #(
  parameter int POOL_ENTRIES = cda_pkg::POOL_ENTRIES_DEF,
  parameter int MAX_RECORDS  = cda_pkg::MAX_RECORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  cda_pkg::req_word_t req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output cda_pkg::rsp_word_t rsp
);
  import cda_pkg::*;

  cda_cmd_t cmd;
  cda_sts_t sts;

  // Sequence each word through load, search and commit.
  cda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold the map and records; search, update and register the response.
  cda_dpath #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .MAX_RECORDS  (MAX_RECORDS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== bench/cda_bench_pkg.sv =====
// Scoreboard for the contiguous descriptor allocator bench: pool and record-list predictor
// plus the queue of expected response words. Depends on cda_pkg.
`timescale 1ns / 1ps

package cda_bench_pkg;

  import cda_pkg::*;

  localparam int POOL    = POOL_ENTRIES_DEF;
  localparam int MAX_REC = MAX_RECORDS_DEF;

  class pool_scoreboard;
    logic [31:0] used_map;
    logic [4:0]  rec_start [MAX_REC];
    logic [5:0]  rec_len [MAX_REC];
    bit          rec_act [MAX_REC];
    int          fill;
    rsp_word_t   expected_rsp[$];

    int errors;
    int checked;
    int n_op [4];
    int n_list_full, n_no_space, n_bad_range, n_not_found, n_hw_fail;

    function new();
      used_map = '0;
      fill = 0;
      errors = 0;
      checked = 0;
      n_list_full = 0;
      n_no_space = 0;
      n_bad_range = 0;
      n_not_found = 0;
      n_hw_fail = 0;
      foreach (n_op[j]) n_op[j] = 0;
      foreach (rec_start[j]) begin
        rec_start[j] = '0;
        rec_len[j] = '0;
        rec_act[j] = 1'b0;
      end
    endfunction

    function logic [31:0] span_bits(int start, int len);
      logic [31:0] m;
      int j;
      m = '0;
      for (j = start; j < start + len && j < POOL; j++) m[j] = 1'b1;
      return m;
    endfunction

    // Close the gap left by record k, keeping the others in order.
    function void remove_record(int k);
      int j;
      for (j = k; j + 1 < fill; j++) begin
        rec_start[j] = rec_start[j+1];
        rec_len[j]   = rec_len[j+1];
        rec_act[j]   = rec_act[j+1];
      end
      fill--;
    endfunction

    function rsp_word_t predict_word(req_word_t w);
      rsp_word_t r;
      logic [31:0] m;
      int len, first, i, k, s, n;
      bit hit;
      r = '0;
      len = int'(w.run_length);
      first = int'(w.first_index);
      hit = 1'b0;
      case (w.opcode)
        OP_ALLOC: begin
          r.status = ST_NO_SPACE;
          if (len != 0 && len <= POOL) begin
            for (i = 0; i + len <= POOL && !hit; i++) begin
              m = span_bits(i, len);
              if ((used_map & m) == '0) begin
                hit = 1'b1;
                used_map |= m;
                r.status = ST_OK;
                r.run_start = i[4:0];
                if (fill < MAX_REC) begin
                  rec_start[fill] = i[4:0];
                  rec_len[fill] = len[5:0];
                  rec_act[fill] = 1'b0;
                  fill++;
                end else begin
                  n_list_full++;
                end
              end
            end
          end
        end
        OP_ACTIVATE: begin
          if (len == 0) begin
            r.status = ST_BAD_RANGE;
          end else begin
            r.status = ST_NOT_FOUND;
            for (k = 0; k < fill && !hit; k++) begin
              if (rec_start[k] == w.first_index && rec_len[k] == w.run_length && !rec_act[k]) begin
                rec_act[k] = 1'b1;
                r.status = ST_OK;
                hit = 1'b1;
              end
            end
          end
        end
        OP_COMPLETE: begin
          for (k = 0; k < fill && !hit; k++) begin
            if (rec_act[k]) begin
              hit = 1'b1;
              s = int'(rec_start[k]);
              n = int'(rec_len[k]);
              if (n != 0 && s + n <= POOL) begin
                used_map &= ~span_bits(s, n);
                r.run_start = s[4:0];
                r.run_freed = n[5:0];
              end
              remove_record(k);
            end
          end
          r.status = w.outcome ? ST_HW_FAIL : ST_OK;
        end
        default: begin
          if (len != 0 && first + len <= POOL) begin
            used_map &= ~span_bits(first, len);
            r.run_start = w.first_index;
            r.run_freed = w.run_length;
          end else begin
            r.status = ST_BAD_RANGE;
          end
        end
      endcase
      r.records_held = fill[4:0];
      r.busy_map = used_map;
      case (r.status)
        ST_NO_SPACE:  n_no_space++;
        ST_BAD_RANGE: n_bad_range++;
        ST_NOT_FOUND: n_not_found++;
        ST_HW_FAIL:   n_hw_fail++;
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(req_word_t w);
      n_op[w.opcode]++;
      expected_rsp.push_back(predict_word(w));
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_response(rsp_word_t got);
      rsp_word_t want;
      if (expected_rsp.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected response word, expected none, got 0x%0h", $time, got);
        return;
      end
      want = expected_rsp.pop_front();
      checked++;
      cmp_field("status", 32'(want.status), 32'(got.status));
      cmp_field("run_start", 32'(want.run_start), 32'(got.run_start));
      cmp_field("run_freed", 32'(want.run_freed), 32'(got.run_freed));
      cmp_field("records_held", 32'(want.records_held), 32'(got.records_held));
      cmp_field("busy_map", want.busy_map, got.busy_map);
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
// Top-level bench for the contiguous descriptor allocator: directed and random request words
// with random idling on both channels. Depends on cda_pkg, cda_bench_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  import cda_pkg::*;
  import cda_bench_pkg::*;

  localparam int RANDOM_WORDS = 1250;
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off to back the block up
  localparam int CYCLE_LIMIT  = 600000;  // far beyond the slowest legal run

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_word_t rsp;

  int  cycles = 0;
  bit  squeeze = 1'b0;    // set by the stimulus, cleared by the receiver after its hold-off
  bit  calm_send = 1'b0;  // sender stretch without gaps

  pool_scoreboard sb = new();

  contiguous_descriptor_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both channels at the rising edge; inputs only move on the falling edge,
  // so what is seen here is stable.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d response words outstanding",
               $time, cycles, sb.expected_rsp.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stall bursts, calm stretches, and one long hold-off on request.
  initial begin
    int stall_left;
    int phase_cyc;
    int r;
    bit calm;
    stall_left = 0;
    phase_cyc = 0;
    calm = 1'b0;
    forever begin
      @(negedge clk);
      phase_cyc++;
      if (phase_cyc == 200) begin
        phase_cyc = 0;
        calm = ($urandom_range(0, 3) == 0);
      end
      if (squeeze) begin
        // Hold off long enough for the block to fill and stall its input.
        rsp_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        squeeze = 1'b0;
      end else if (calm) begin
        rsp_stall = 1'b0;
      end else if (stall_left > 0) begin
        rsp_stall = 1'b1;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          rsp_stall = 1'b0;
        end else if (r < 93) begin
          rsp_stall = 1'b1;
          stall_left = $urandom_range(0, 3);
        end else begin
          rsp_stall = 1'b1;
          stall_left = $urandom_range(9, 39);
        end
      end
    end
  end

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input req_word_t w);
    @(negedge clk);
    req = w;
    req_valid = 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Drop valid for an idle gap of length n; with n of zero valid stays high for the next word.
  task automatic idle_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      req_valid = 1'b0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (squeeze || calm_send) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_spaced(input req_word_t w);
    send_word(w);
    idle_sender(pick_gap());
  endtask

  function automatic req_word_t mk(input logic [1:0] op, input int len, input int first,
                                   input bit oc);
    req_word_t w;
    w.opcode = op;
    w.run_length = len[5:0];
    w.first_index = first[4:0];
    w.outcome = oc;
    return w;
  endfunction

  // Mostly well-formed traffic: activations aim at inactive records the predictor
  // holds, frees mostly stay in bounds; the rest is random noise.
  function automatic req_word_t make_random_word();
    req_word_t w;
    int r;
    int r2;
    int k;
    int first;
    int idle_recs[$];
    w.run_length = 6'($urandom);
    w.first_index = 5'($urandom);
    w.outcome = 1'($urandom);
    r = $urandom_range(0, 99);
    r2 = $urandom_range(0, 99);
    if (r < 35) begin
      w.opcode = OP_ALLOC;
      if (r2 < 70) w.run_length = 6'($urandom_range(1, 4));
      else if (r2 < 85) w.run_length = 6'($urandom_range(5, 12));
      else if (r2 < 93) w.run_length = 6'($urandom_range(13, 32));
    end else if (r < 60) begin
      w.opcode = OP_ACTIVATE;
      for (k = 0; k < sb.fill; k++)
        if (!sb.rec_act[k]) idle_recs.push_back(k);
      if (idle_recs.size() != 0 && r2 < 80) begin
        k = idle_recs[$urandom_range(0, idle_recs.size() - 1)];
        w.first_index = sb.rec_start[k];
        w.run_length = sb.rec_len[k];
      end
    end else if (r < 85) begin
      w.opcode = OP_COMPLETE;
      w.outcome = ($urandom_range(0, 4) == 0);
    end else begin
      w.opcode = OP_FREE;
      if (r2 < 15) begin
        w.first_index = '0;
        w.run_length = 6'(POOL);
      end else if (r2 < 65) begin
        first = $urandom_range(0, POOL - 1);
        w.first_index = first[4:0];
        w.run_length = 6'($urandom_range(1, POOL - first));
      end
    end
    return w;
  endfunction

  initial begin
    int i;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: bad lengths, empty lists, bounds, full pool, lowest-fit and record flow.
    send_spaced(mk(OP_ALLOC, 0, 7, 1'b1));        // zero length
    send_spaced(mk(OP_ALLOC, 63, 31, 1'b0));      // length far past the pool
    send_spaced(mk(OP_ALLOC, 33, 0, 1'b0));       // one past the pool
    send_spaced(mk(OP_ACTIVATE, 0, 0, 1'b0));     // zero length
    send_spaced(mk(OP_ACTIVATE, 1, 0, 1'b1));     // no record yet
    send_spaced(mk(OP_COMPLETE, 0, 0, 1'b0));     // done, nothing active
    send_spaced(mk(OP_COMPLETE, 0, 31, 1'b1));    // error, nothing active
    send_spaced(mk(OP_FREE, 2, 31, 1'b0));        // run ends past the pool
    send_spaced(mk(OP_FREE, 0, 5, 1'b0));         // zero length
    send_spaced(mk(OP_FREE, 4, 3, 1'b0));         // clears already free entries
    send_spaced(mk(OP_ALLOC, 32, 0, 1'b0));       // whole pool
    send_spaced(mk(OP_ALLOC, 1, 0, 1'b0));        // no space left
    send_spaced(mk(OP_ACTIVATE, 32, 0, 1'b0));
    send_spaced(mk(OP_ACTIVATE, 32, 0, 1'b0));    // already active
    send_spaced(mk(OP_COMPLETE, 0, 0, 1'b0));     // frees the whole pool
    send_spaced(mk(OP_ALLOC, 3, 0, 1'b0));
    send_spaced(mk(OP_ALLOC, 5, 0, 1'b0));
    send_spaced(mk(OP_FREE, 3, 0, 1'b0));         // hole at the bottom
    send_spaced(mk(OP_ALLOC, 2, 0, 1'b0));        // lowest fit lands in the hole
    send_spaced(mk(OP_ACTIVATE, 5, 3, 1'b0));
    send_spaced(mk(OP_COMPLETE, 0, 0, 1'b1));     // error still frees the record
    send_spaced(mk(OP_FREE, 1, 31, 1'b0));        // last entry
    send_spaced(mk(OP_FREE, 32, 0, 1'b0));        // whole map

    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0) calm_send = ($urandom_range(0, 3) == 0);
      if (i == 200) squeeze = 1'b1;
      send_spaced(make_random_word());
    end
    idle_sender(1);

    // Drain: wait for every expected word, then a few more cycles for strays.
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d responses: %0d allocate, %0d activate, %0d complete, %0d range free.",
             sb.checked, sb.n_op[OP_ALLOC], sb.n_op[OP_ACTIVATE], sb.n_op[OP_COMPLETE],
             sb.n_op[OP_FREE]);
    $display("Seen %0d no-space, %0d bad range, %0d not found, %0d hw fail, %0d full-list allocs.",
             sb.n_no_space, sb.n_bad_range, sb.n_not_found, sb.n_hw_fail, sb.n_list_full);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
